FILE: sv/ptti_pkg.sv
// Package for the pose table time interpolator.
// Holds table constants, function codes, result kinds and shared types.
// No dependencies.
package ptti_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = AddrW + 1;
  localparam int unsigned TimeW      = 63;
  localparam int unsigned ValW       = 32;
  localparam int unsigned NVals      = 7;
  localparam int unsigned EntryW     = TimeW + NVals * ValW;

  localparam logic [1:0] FuncLoad  = 2'd0;
  localparam logic [1:0] FuncQuery = 2'd1;
  localparam logic [1:0] FuncClear = 2'd2;

  localparam logic [1:0] KindNone   = 2'd0;
  localparam logic [1:0] KindNear   = 2'd1;
  localparam logic [1:0] KindInterp = 2'd2;

  localparam logic [31:0] NearReset   = 32'd150000;
  localparam logic [31:0] InterpReset = 32'd500000;

  localparam logic CfgNear   = 1'b0;
  localparam logic CfgInterp = 1'b1;

  // one interpolation request: offset values y0, y1 and weights a, b
  typedef struct packed {
    logic        start;
    logic [31:0] y0;
    logic [31:0] y1;
    logic [63:0] a;
    logic [63:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } div_rsp_t;
endpackage

FILE: sv/ptti_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module ptti_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: sv/ptti_div.sv
// Shift-add multiplier then restoring divider, one bit per cycle, for one value.
// Depends on ptti_pkg. Quotient rounds toward zero, saturated to 32-bit signed.
module ptti_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptti_pkg::div_req_t req_i,
  output ptti_pkg::div_rsp_t rsp_o
);
  logic        mul_q, mul_d;
  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [31:0] y0_q, y0_d, y1_q, y1_d;
  logic [63:0] a_q, a_d, b_q, b_d;
  logic [95:0] num_q, num_d;
  logic [63:0] den_q, den_d;
  logic [64:0] rem_q, rem_d;
  logic [33:0] quo_q, quo_d;
  logic        sat_q, sat_d;
  logic        done_q, done_d;
  logic [31:0] res_q, res_d;
  logic [95:0] acc;
  logic [64:0] shifted;
  logic        ge;
  logic [33:0] qn;

  always_comb begin
    mul_d = mul_q; busy_d = busy_q; cnt_d = cnt_q; y0_d = y0_q; y1_d = y1_q;
    a_d = a_q; b_d = b_q; num_d = num_q; den_d = den_q;
    rem_d = rem_q; quo_d = quo_q; sat_d = sat_q; done_d = 1'b0; res_d = res_q;
    // y0*a + y1*b stays below 2^96: both products below 2^95
    acc = {num_q[94:0], 1'b0} + (y0_q[31] ? {32'd0, a_q} : 96'd0)
          + (y1_q[31] ? {32'd0, b_q} : 96'd0);
    shifted = {rem_q[63:0], num_q[95]};
    ge = shifted >= {1'b0, den_q};
    qn = {quo_q[32:0], ge};
    if (req_i.start) begin
      mul_d = 1'b1; busy_d = 1'b0; cnt_d = 7'd32; num_d = '0;
      y0_d = req_i.y0; y1_d = req_i.y1; a_d = req_i.a; b_d = req_i.b;
    end else if (mul_q) begin
      num_d = acc;
      y0_d = {y0_q[30:0], 1'b0};
      y1_d = {y1_q[30:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        mul_d = 1'b0; busy_d = 1'b1; cnt_d = 7'd96;
        den_d = a_q + b_q; rem_d = '0; quo_d = '0; sat_d = 1'b0;
      end
    end else if (busy_q) begin
      rem_d = ge ? shifted - {1'b0, den_q} : shifted;
      num_d = {num_q[94:0], 1'b0};
      // any quotient bit at 32 or above means overflow
      if (quo_q[32]) sat_d = 1'b1;
      quo_d = qn;
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (sat_q || quo_q[32] || qn[33] || qn[32]) begin
          res_d = 32'h7FFF_FFFF;
        end else if (!qn[31] && (rem_d != '0)) begin
          res_d = (qn[31:0] + 32'd1) ^ 32'h8000_0000;
        end else begin
          res_d = qn[31:0] ^ 32'h8000_0000;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= 1'b0; busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      mul_q <= mul_d; busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y0_q <= y0_d; y1_q <= y1_d; a_q <= a_d; b_q <= b_d;
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d; quo_q <= quo_d;
    sat_q <= sat_d; res_q <= res_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q;
endmodule

FILE: sv/ptti_ctrl.sv
// Sequencer: loads, clears, query scan over the entry RAM and interpolation.
// Depends on ptti_pkg, ptti_ram and ptti_div.
module ptti_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [62:0] time_i,
  input  logic [ptti_pkg::NVals*ptti_pkg::ValW-1:0] vals_i,
  input  logic [31:0] near_win_i,
  input  logic [31:0] interp_win_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [62:0] ptime_o,
  output logic [ptti_pkg::NVals*ptti_pkg::ValW-1:0] ovals_o
);
  localparam int unsigned VW = ptti_pkg::NVals * ptti_pkg::ValW;
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFirst = 3'd1;
  localparam logic [2:0] StLast  = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] st_q, st_d;
  logic [ptti_pkg::CountW-1:0] count_q, count_d;
  logic [ptti_pkg::CountW-1:0] idx_q, idx_d;
  logic [62:0] qt_q, qt_d, first_q, first_d, prevt_q, prevt_d;
  logic [62:0] b0t_q, b0t_d, b1t_q, b1t_d;
  logic [VW-1:0] prevv_q, prevv_d, b0v_q, b0v_d, b1v_q, b1v_d, res_q, res_d;
  logic [1:0] kind_q, kind_d;
  logic [2:0] lane_q, lane_d;
  logic ovalid_q, ovalid_d;
  logic [1:0] okind_q, okind_d;
  logic [62:0] optime_q, optime_d;
  logic [VW-1:0] ores_q, ores_d;
  logic kick_q;

  logic we;
  logic [ptti_pkg::AddrW-1:0] raddr;
  logic [ptti_pkg::EntryW-1:0] rdata;
  logic [62:0] rt;
  logic [VW-1:0] rv;
  ptti_pkg::div_req_t dreq;
  ptti_pkg::div_rsp_t drsp;
  logic [63:0] da, db;
  logic [31:0] y0, y1;
  logic [63:0] tdist;
  logic        in_acc;

  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == StIdle);
  assign we = in_acc && func_i == ptti_pkg::FuncLoad
              && count_q < ptti_pkg::CountW'(ptti_pkg::TableDepth);
  assign rt = rdata[62:0];
  assign rv = rdata[ptti_pkg::EntryW-1:63];

  ptti_ram #(.Width(ptti_pkg::EntryW), .Depth(ptti_pkg::TableDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(count_q[ptti_pkg::AddrW-1:0]),
    .wdata_i({vals_i, time_i}), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign da = {1'b0, b1t_q - qt_q};
  assign db = {1'b0, qt_q - b0t_q};
  assign y0 = b0v_q[lane_q*32 +: 32] ^ 32'h8000_0000;
  assign y1 = b1v_q[lane_q*32 +: 32] ^ 32'h8000_0000;
  ptti_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));
  assign tdist = {1'b0, (rt >= qt_q) ? rt - qt_q : qt_q - rt};

  always_comb begin
    st_d = st_q; count_d = count_q; idx_d = idx_q; qt_d = qt_q;
    first_d = first_q; prevt_d = prevt_q; prevv_d = prevv_q;
    b0t_d = b0t_q; b1t_d = b1t_q; b0v_d = b0v_q; b1v_d = b1v_q;
    res_d = res_q; kind_d = kind_q; lane_d = lane_q; ovalid_d = ovalid_q;
    okind_d = okind_q; optime_d = optime_q; ores_d = ores_q;
    raddr = idx_q[ptti_pkg::AddrW-1:0];
    dreq = '0;
    dreq.start = kick_q;
    dreq.y0 = y0;
    dreq.y1 = y1;
    dreq.a = da;
    dreq.b = db;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_acc) begin
          qt_d = time_i;
          if (we) count_d = count_q + 1'b1;
          if (func_i == ptti_pkg::FuncClear) count_d = '0;
          if (func_i == ptti_pkg::FuncQuery) begin
            kind_d = ptti_pkg::KindNone; res_d = '0;
            if (count_q == '0) begin
              st_d = StOut;
            end else begin
              raddr = '0;
              st_d = StFirst;
            end
          end
        end
      end
      StFirst: begin
        first_d = rt;
        raddr = ptti_pkg::AddrW'(count_q - 1'b1);
        st_d = StLast;
      end
      StLast: begin
        if (qt_q < first_q || qt_q > rt) begin
          st_d = StOut;
        end else begin
          idx_d = '0; raddr = '0; st_d = StScan;
        end
      end
      StScan: begin
        // rdata holds entry idx_q; read idx_q+1 ahead
        raddr = ptti_pkg::AddrW'(idx_q + 1'b1);
        prevt_d = rt; prevv_d = rv; idx_d = idx_q + 1'b1;
        if (tdist < {32'd0, near_win_i}) begin
          kind_d = ptti_pkg::KindNear; res_d = rv; st_d = StOut;
        end else begin
          if (idx_q != '0 && rt > qt_q && prevt_q < qt_q
              && {1'b0, rt - qt_q} < {32'd0, interp_win_i}) begin
            kind_d = ptti_pkg::KindInterp;
            b0t_d = prevt_q; b0v_d = prevv_q; b1t_d = rt; b1v_d = rv;
          end
          if (idx_q + 1'b1 == count_q) begin
            if (kind_d == ptti_pkg::KindInterp) begin
              lane_d = '0; st_d = StDiv;
            end else st_d = StOut;
          end
        end
      end
      StDiv: begin
        if (drsp.done) begin
          res_d[lane_q*32 +: 32] = drsp.value;
          if (lane_q == 3'(ptti_pkg::NVals - 1)) st_d = StOut;
          else lane_d = lane_q + 1'b1;
        end
      end
      StOut: begin
        // hold until the output register is free or drains this cycle
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          okind_d = kind_q;
          optime_d = (kind_q == ptti_pkg::KindNear) ? qt_q : '0;
          ores_d = (kind_q == ptti_pkg::KindNone) ? '0 : res_q;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // kick the divider on entry to a lane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) kick_q <= 1'b0;
    else kick_q <= (st_d == StDiv) && (st_q != StDiv || drsp.done)
                   && !(drsp.done && lane_q == 3'(ptti_pkg::NVals - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; count_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; count_q <= count_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; qt_q <= qt_d; first_q <= first_d; prevt_q <= prevt_d;
    prevv_q <= prevv_d; b0t_q <= b0t_d; b1t_q <= b1t_d; b0v_q <= b0v_d;
    b1v_q <= b1v_d; res_q <= res_d; kind_q <= kind_d; lane_q <= lane_d;
    okind_q <= okind_d; optime_q <= optime_d; ores_q <= ores_d;
  end

  assign out_valid_o = ovalid_q;
  assign kind_o  = okind_q;
  assign ptime_o = optime_q;
  assign ovals_o = ores_q;
endmodule

FILE: sv/pose_table_time_interpolator.sv
// channel | dir | tdata fields (low bit first)                      | tuser
// s_axis  | in  | time_stamp, trans_x..z, quat_w..z (287 b, pad 288) | func
// m_axis  | out | pose_time, out_trans_x..z, out_quat_w..z (288)     | match_kind
// cfg     | in  | index 0 near_window, 1 interp_window               | -
// A query on an empty table goes straight to the result; one outside the span
// ends after reading the first and last entries; otherwise the scan reads
// entries in order until a near match or the last one (up to 1024).
// Interpolation adds seven divider passes, each a multiply then a divide.
// Reset is asynchronous and empties the table. Loads and clears pass a waiting
// result; a query holds in its last step until the output register is free.
module pose_table_time_interpolator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,  // time_stamp, trans_x/y/z, quat_w/x/y/z
  input  logic [1:0]   s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,  // pose_time, out_trans_x/y/z, out_quat_w/x/y/z
  output logic [1:0]   m_axis_tuser,  // match_kind
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_wdata_i
);
  logic [31:0] near_q, interp_q;
  logic [62:0] ptime;
  logic [223:0] ovals;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= ptti_pkg::NearReset; interp_q <= ptti_pkg::InterpReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ptti_pkg::CfgNear) near_q <= cfg_wdata_i;
      else interp_q <= cfg_wdata_i;
    end
  end

  ptti_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .func_i(s_axis_tuser), .time_i(s_axis_tdata[62:0]),
    .vals_i(s_axis_tdata[286:63]),
    .near_win_i(near_q), .interp_win_i(interp_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .kind_o(m_axis_tuser), .ptime_o(ptime), .ovals_o(ovals)
  );

  assign m_axis_tdata = {1'b0, ovals, ptime};
endmodule

FILE: sv/ptti_checker.sv
// Port-level checker for pose_table_time_interpolator, bound to the top level.
// Depends on ptti_pkg.
module ptti_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [287:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word dropped");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ptti_pkg::KindNone
      || m_axis_tuser == ptti_pkg::KindNear || m_axis_tuser == ptti_pkg::KindInterp))
    else $error("illegal match kind");
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ptti_pkg::KindNone |-> m_axis_tdata == '0)
    else $error("no-pose result not zero");
  a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ptti_pkg::KindInterp |-> m_axis_tdata[62:0] == '0)
    else $error("interpolated result carries a time");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({s_axis_tready, m_axis_tvalid}))
    else $error("handshake unknown");
endmodule

bind pose_table_time_interpolator ptti_checker u_ptti_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

FILE: tb/sv/testbench.sv
// Testbench for the pose table time interpolator: directed and random loads,
// queries and clears, checked word by word against an in-bench table model.
// Depends on ptti_pkg and pose_table_time_interpolator.
module testbench;
  typedef struct packed {
    logic [1:0]                                kind;
    logic [ptti_pkg::TimeW-1:0]                ptime;
    logic [ptti_pkg::NVals-1:0][31:0]          vals;
  } pose_res_t;

  localparam logic [1:0] FuncSpare = 2'd3;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;   // time_stamp, trans_x/y/z, quat_w/x/y/z
  logic [1:0]   s_axis_tuser = '0;   // func
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;        // pose_time, out_trans_x/y/z, out_quat_w/x/y/z
  logic [1:0]   m_axis_tuser;        // match_kind
  logic         cfg_we_i = 1'b0;
  logic         cfg_index_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;

  pose_table_time_interpolator i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // table model
  logic [ptti_pkg::TimeW-1:0]       tbl_time [ptti_pkg::TableDepth];
  logic [ptti_pkg::NVals-1:0][31:0] tbl_vals [ptti_pkg::TableDepth];
  int unsigned            tbl_count = 0;
  logic [31:0]            near_win = ptti_pkg::NearReset;
  logic [31:0]            interp_win = ptti_pkg::InterpReset;

  pose_res_t   pending_poses[$];
  int unsigned errors = 0;
  int unsigned n_queries = 0;
  int unsigned n_sent = 0;
  int unsigned n_interp = 0;
  int unsigned n_near = 0;
  int unsigned src_idle = 0;
  int unsigned snk_stall = 0;
  int unsigned quiet_cycles = 0;
  localparam int unsigned WatchdogLimit = 20000;

  function automatic logic [31:0] lerp_value(logic [31:0] y0, logic [31:0] y1,
                                             logic [63:0] a, logic [63:0] b);
    logic [127:0] num, den, quo, rem;
    num = {96'b0, y0 ^ 32'h8000_0000} * {64'b0, a} + {96'b0, y1 ^ 32'h8000_0000} * {64'b0, b};
    den = {64'b0, a + b};
    quo = num / den;
    rem = num % den;
    // floor of offset value; step toward zero when negative and inexact
    if (quo < 128'h8000_0000 && rem != 0) quo = quo + 1;
    if (quo > 128'hFFFF_FFFF) return 32'h7FFF_FFFF;
    return quo[31:0] ^ 32'h8000_0000;
  endfunction

  function automatic pose_res_t lookup_pose(logic [ptti_pkg::TimeW-1:0] t);
    pose_res_t   res;
    logic [63:0] x, xp, tq, tdist;
    res = '0;
    tq = {1'b0, t};
    if (tbl_count > 0 && t >= tbl_time[0] && t <= tbl_time[tbl_count-1]) begin
      for (int i = 0; i < tbl_count; i++) begin
        x = {1'b0, tbl_time[i]};
        tdist = (x >= tq) ? x - tq : tq - x;
        if (tdist < {32'b0, near_win}) begin
          res.kind = ptti_pkg::KindNear;
          res.ptime = t;
          res.vals = tbl_vals[i];
          break;
        end
        if (i > 0) begin
          xp = {1'b0, tbl_time[i-1]};
          if (x > tq && xp < tq && x - tq < {32'b0, interp_win}) begin
            res.kind = ptti_pkg::KindInterp;
            for (int j = 0; j < ptti_pkg::NVals; j++)
              res.vals[j] = lerp_value(tbl_vals[i-1][j], tbl_vals[i][j], x - tq, tq - xp);
          end
        end
      end
    end
    if (res.kind == ptti_pkg::KindNone) res = '0;
    return res;
  endfunction

  task automatic send_word(logic [1:0] func, logic [ptti_pkg::TimeW-1:0] t,
                           logic [ptti_pkg::NVals-1:0][31:0] vals);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = func;
    s_axis_tdata = {1'b0, vals, t};
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    case (func)
      ptti_pkg::FuncLoad: begin
        if (tbl_count < ptti_pkg::TableDepth) begin
          tbl_time[tbl_count] = t;
          tbl_vals[tbl_count] = vals;
          tbl_count++;
        end
      end
      ptti_pkg::FuncQuery: begin
        pending_poses = {pending_poses, lookup_pose(t)};
        n_queries++;
      end
      ptti_pkg::FuncClear: tbl_count = 0;
      default: ;
    endcase
  endtask

  function automatic logic [ptti_pkg::NVals-1:0][31:0] rand_vals();
    logic [ptti_pkg::NVals-1:0][31:0] v;
    for (int j = 0; j < ptti_pkg::NVals; j++) v[j] = $urandom;
    return v;
  endfunction

  task automatic load(logic [ptti_pkg::TimeW-1:0] t);
    send_word(ptti_pkg::FuncLoad, t, rand_vals());
  endtask

  task automatic query(logic [ptti_pkg::TimeW-1:0] t);
    send_word(ptti_pkg::FuncQuery, t, rand_vals());
  endtask

  task automatic clear_table();
    send_word(ptti_pkg::FuncClear, 63'({$urandom, $urandom}), rand_vals());
  endtask

  // hold the sender until every result is back, then let loads settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_poses.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] value);
    drain();
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == ptti_pkg::CfgNear) near_win = value;
    else interp_win = value;
  endtask

  // receiver stall pattern
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_stall);

  always @(posedge clk_i) begin
    pose_res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.ptime = m_axis_tdata[ptti_pkg::TimeW-1:0];
      got.vals = m_axis_tdata[ptti_pkg::TimeW +: ptti_pkg::NVals*32];
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected result kind %0d", $time, got.kind);
        errors++;
      end else begin
        want = pending_poses.pop_front();
        if (want.kind == ptti_pkg::KindInterp) n_interp++;
        if (want.kind == ptti_pkg::KindNear) n_near++;
        if (got.kind !== want.kind) begin
          $display("%0t: match_kind expected %0d actual %0d", $time, want.kind, got.kind);
          errors++;
        end
        if (got.ptime !== want.ptime) begin
          $display("%0t: pose_time expected %h actual %h", $time, want.ptime, got.ptime);
          errors++;
        end
        for (int j = 0; j < ptti_pkg::NVals; j++)
          if (got.vals[j] !== want.vals[j]) begin
            $display("%0t: value %0d expected %h actual %h", $time, j, want.vals[j],
                     got.vals[j]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_empty_and_span();
    query(63'd5000000);
    load(63'd1000000);
    load(63'd2000000);
    load(63'd3000000);
    query(63'd0);
    query(63'd3000001 + 63'd200000);
    query(63'd1000000);
    query(63'd3000000);
    query(63'd1900000);
    send_word(FuncSpare, 63'd1500000, rand_vals());
    clear_table();
    query(63'd1000000);
  endtask

  task automatic test_interp_extremes();
    logic [ptti_pkg::NVals-1:0][31:0] lo_v, hi_v;
    for (int j = 0; j < ptti_pkg::NVals; j++) begin
      lo_v[j] = (j % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      hi_v[j] = (j % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    send_word(ptti_pkg::FuncLoad, 63'd1000000, lo_v);
    send_word(ptti_pkg::FuncLoad, 63'd1400000, hi_v);
    send_word(ptti_pkg::FuncLoad, 63'd1450000, lo_v);
    query(63'd1200001);
    query(63'd1399999);
    query(63'd1425000);
    clear_table();
    send_word(ptti_pkg::FuncLoad, 63'd0, lo_v);
    send_word(ptti_pkg::FuncLoad, {63{1'b1}}, hi_v);
    query({1'b0, {62{1'b1}}});
    query({63{1'b1}});
    clear_table();
  endtask

  task automatic test_windows();
    write_cfg(ptti_pkg::CfgNear, 32'd0);
    write_cfg(ptti_pkg::CfgInterp, 32'hFFFF_FFFF);
    load(63'd100);
    load(63'd200);
    load(63'd1000);
    query(63'd100);
    query(63'd150);
    query(63'd999);
    write_cfg(ptti_pkg::CfgNear, 32'hFFFF_FFFF);
    write_cfg(ptti_pkg::CfgInterp, 32'd0);
    query(63'd500);
    write_cfg(ptti_pkg::CfgNear, ptti_pkg::NearReset);
    write_cfg(ptti_pkg::CfgInterp, ptti_pkg::InterpReset);
    clear_table();
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned   sent;
    int unsigned   k;
    logic [62:0]   t, t0, step;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(9);
      if (k == 0) begin
        clear_table();
        sent++;
      end else if (k == 1) begin
        send_word(2'($urandom_range(3)), 63'({$urandom, $urandom}), rand_vals());
        sent++;
      end else begin
        if ($urandom_range(1)) begin
          clear_table();
          sent++;
        end
        step = 63'($urandom_range(800000, 1000));
        t0 = 63'({$urandom, $urandom} >> $urandom_range(40));
        t = t0;
        k = $urandom_range(12, 1);
        for (int i = 0; i < k; i++) begin
          load(t);
          t = t + 63'($urandom_range(32'(step) * 2))
              + (($urandom_range(7) == 0) ? 63'd0 : 63'd1);
          sent++;
        end
        k = $urandom_range(4, 1);
        for (int i = 0; i < k; i++) begin
          query(t0 - step + 63'($urandom) % (t - t0 + 63'd2 * step));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_and_span();
    test_interp_extremes();
    test_windows();
    for (int ph = 0; ph < 4; ph++) begin
      src_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 30 : 73) : 0;
      snk_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 30 : 73) : 0;
      write_cfg(ptti_pkg::CfgNear, 32'($urandom_range(400000)));
      write_cfg(ptti_pkg::CfgInterp, 32'($urandom_range(1200000)));
      test_random(125);
    end
    drain();
    repeat (2000) @(negedge clk_i);
    if (pending_poses.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_poses.size());
      errors++;
    end
    $display("Sent %0d words with %0d queries (%0d near, %0d interpolated),",
             n_sent, n_queries, n_near, n_interp);
    $display("over span edges, window extremes and four idle patterns.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
